// ===== src/bpcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Box pair collision resolver: shared types and constants
// Item and stage records, status and outcome codes, object check and mod-3.
// ----------------------------------------------------------------------------
package bpcr_pkg;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic [1:0] OC_NONE    = 2'd0;
	localparam logic [1:0] OC_PHASE   = 2'd1;
	localparam logic [1:0] OC_SCALE   = 2'd2;
	localparam logic [1:0] OC_CORRECT = 2'd3;

	localparam logic [6:0]  PHASE_LIMIT = 7'd72;
	localparam logic [6:0]  CELL_LIMIT  = 7'd81;
	localparam logic [63:0] S64_MIN     = {1'b1, 63'd0};

	typedef struct packed {
		logic signed [63:0] pos_x;
		logic signed [63:0] pos_y;
		logic signed [63:0] half_width;
		logic signed [63:0] half_height;
		logic [6:0]         phase;
		logic signed [63:0] scale_num;
		logic signed [63:0] scale_den;
		logic [6:0]         grid_cell;
		logic               tags_present;
	} obj_t;

	// After the first step: sums of half sizes and centre differences.
	typedef struct packed {
		logic [1:0]         status;
		logic signed [63:0] sum_x;
		logic signed [63:0] sum_y;
		logic signed [63:0] dx;
		logic signed [63:0] dy;
		logic signed [63:0] bx;
		logic signed [63:0] by;
		logic               phase_ok;
		logic               scale_ok;
	} diff_t;

	// After the second step: signed overlaps on each axis.
	typedef struct packed {
		logic [1:0]         status;
		logic signed [63:0] ov_x;
		logic signed [63:0] ov_y;
		logic               dx_neg;
		logic               dy_neg;
		logic signed [63:0] bx;
		logic signed [63:0] by;
		logic               phase_ok;
		logic               scale_ok;
	} ovl_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [1:0]         outcome;
		logic signed [63:0] separation_x;
		logic signed [63:0] separation_y;
		logic [62:0]        penetration_x;
		logic [62:0]        penetration_y;
		logic signed [63:0] correction_x;
		logic signed [63:0] correction_y;
		logic signed [63:0] corrected_x;
		logic signed [63:0] corrected_y;
		logic               phase_ok;
		logic               scale_ok;
	} res_t;

	function automatic logic obj_valid(input obj_t o);
		return (o.scale_den > 64'sd0) && (o.phase < PHASE_LIMIT) &&
			(o.grid_cell < CELL_LIMIT) && o.tags_present &&
			!o.half_width[63] && !o.half_height[63];
	endfunction

	// Residue mod 3 of a 7-bit value: base-4 digits each weigh 1 mod 3.
	function automatic logic [1:0] mod3(input logic [6:0] v);
		logic [3:0] s;
		logic [2:0] t;
		s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[6]);
		t = 3'(s[1:0]) + 3'(s[3:2]);
		return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
	endfunction

endpackage

// ===== src/bpcr_front.sv =====
// ----------------------------------------------------------------------------
// Box pair collision resolver: held object and first step
// Stores object A; checks validity, half-size sums and centre differences.
// ----------------------------------------------------------------------------
module bpcr_front import bpcr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  store,
	input  obj_t  obj,
	output diff_t diff
);

	obj_t held_q;
	logic held_valid_q;

	logic signed [64:0] sum_x, sum_y, dx, dy;
	logic               ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_valid_q <= 1'b0;
		end else if (store) begin
			held_q       <= obj;
			held_valid_q <= obj_valid(obj);
		end
	end

	always_comb begin
		sum_x = {held_q.half_width[63], held_q.half_width} +
			{obj.half_width[63], obj.half_width};
		sum_y = {held_q.half_height[63], held_q.half_height} +
			{obj.half_height[63], obj.half_height};
		dx = {obj.pos_x[63], obj.pos_x} - {held_q.pos_x[63], held_q.pos_x};
		dy = {obj.pos_y[63], obj.pos_y} - {held_q.pos_y[63], held_q.pos_y};

		// A difference of magnitude 2^63 has no positive counterpart.
		ovf = (sum_x[64] != sum_x[63]) || (sum_y[64] != sum_y[63]) ||
			(held_q.pos_x == S64_MIN) || (held_q.pos_y == S64_MIN) ||
			(dx[64] != dx[63]) || (dy[64] != dy[63]) ||
			(dx[63:0] == S64_MIN) || (dy[63:0] == S64_MIN);

		if (!held_valid_q || !obj_valid(obj))
			diff.status = ST_INVALID;
		else if (ovf)
			diff.status = ST_OVERFLOW;
		else
			diff.status = ST_OK;

		diff.sum_x    = sum_x[63:0];
		diff.sum_y    = sum_y[63:0];
		diff.dx       = dx[63:0];
		diff.dy       = dy[63:0];
		diff.bx       = obj.pos_x;
		diff.by       = obj.pos_y;
		diff.phase_ok = mod3(held_q.phase) == mod3(obj.phase);
		diff.scale_ok = (held_q.scale_num == obj.scale_num) &&
			(held_q.scale_den == obj.scale_den);
	end

endmodule

// ===== src/bpcr_overlap.sv =====
// ----------------------------------------------------------------------------
// Box pair collision resolver: overlap step
// Overlap per axis is the half-size sum minus the absolute difference.
// ----------------------------------------------------------------------------
module bpcr_overlap import bpcr_pkg::*; (
	input  diff_t diff,
	output ovl_t  ovl
);

	// Folding the absolute value into the add keeps one adder per axis.
	always_comb begin
		ovl.status   = diff.status;
		ovl.ov_x     = diff.dx[63] ? diff.sum_x + diff.dx : diff.sum_x - diff.dx;
		ovl.ov_y     = diff.dy[63] ? diff.sum_y + diff.dy : diff.sum_y - diff.dy;
		ovl.dx_neg   = diff.dx[63];
		ovl.dy_neg   = diff.dy[63];
		ovl.bx       = diff.bx;
		ovl.by       = diff.by;
		ovl.phase_ok = diff.phase_ok;
		ovl.scale_ok = diff.scale_ok;
	end

endmodule

// ===== src/bpcr_resolve.sv =====
// ----------------------------------------------------------------------------
// Box pair collision resolver: resolve step
// Classifies the contact, pushes B along the smaller overlap, forms the result.
// ----------------------------------------------------------------------------
module bpcr_resolve import bpcr_pkg::*; (
	input  ovl_t ovl,
	output res_t res
);

	logic               pos_x, pos_y, x_le_y, sel_x, sel_y, ovf;
	logic [1:0]         outcome;
	logic signed [64:0] nx, ny;

	always_comb begin
		pos_x  = ovl.ov_x > 64'sd0;
		pos_y  = ovl.ov_y > 64'sd0;
		x_le_y = ovl.ov_x <= ovl.ov_y;

		if (!pos_x || !pos_y)
			outcome = OC_NONE;
		else if (!ovl.phase_ok)
			outcome = OC_PHASE;
		else if (!ovl.scale_ok)
			outcome = OC_SCALE;
		else
			outcome = OC_CORRECT;

		// Equal overlaps push along x.
		sel_x = (outcome == OC_CORRECT) && x_le_y;
		sel_y = (outcome == OC_CORRECT) && !x_le_y;

		// Both candidate positions are formed next to the compare.
		nx = ovl.dx_neg ? {ovl.bx[63], ovl.bx} - {ovl.ov_x[63], ovl.ov_x}
			: {ovl.bx[63], ovl.bx} + {ovl.ov_x[63], ovl.ov_x};
		ny = ovl.dy_neg ? {ovl.by[63], ovl.by} - {ovl.ov_y[63], ovl.ov_y}
			: {ovl.by[63], ovl.by} + {ovl.ov_y[63], ovl.ov_y};
		ovf = (sel_x && (nx[64] != nx[63])) || (sel_y && (ny[64] != ny[63]));

		res = '0;
		if (ovl.status != ST_OK) begin
			res.status = ovl.status;
		end else if (ovf) begin
			res.status = ST_OVERFLOW;
		end else begin
			res.status        = ST_OK;
			res.outcome       = outcome;
			res.separation_x  = -ovl.ov_x;
			res.separation_y  = -ovl.ov_y;
			res.penetration_x = pos_x ? ovl.ov_x[62:0] : 63'd0;
			res.penetration_y = pos_y ? ovl.ov_y[62:0] : 63'd0;
			res.correction_x  = !sel_x ? 64'sd0 : ovl.dx_neg ? -ovl.ov_x : ovl.ov_x;
			res.correction_y  = !sel_y ? 64'sd0 : ovl.dy_neg ? -ovl.ov_y : ovl.ov_y;
			res.corrected_x   = sel_x ? nx[63:0] : ovl.bx;
			res.corrected_y   = sel_y ? ny[63:0] : ovl.by;
			res.phase_ok      = ovl.phase_ok;
			res.scale_ok      = ovl.scale_ok;
		end
	end

endmodule

// ===== src/box_pair_collision_resolve.sv =====
// ----------------------------------------------------------------------------
// Box pair collision resolver
// Pairs of axis-aligned boxes in, one contact result per second box out.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+-----------------------------------
//  item     | item_valid / item_ready     | second_of_pair, pos_x .. tags_present
//  result   | result_valid / result_ready | status, outcome, separation_x .. scale_ok
//
// The block takes one item in every cycle while no stalled result backs up
// to the input. An item is registered, passes three short steps (validity
// and differences, overlaps, contact and push) with diff_s2 and ovl_s3
// between them, and its result appears on the result register res_q. An
// item with second_of_pair low only loads the held object A and produces
// no result; the next item already sees the new A. Reset clears all valid
// bits and the held object, which then counts as invalid. A stalled result
// holds the result register; the stages behind it keep filling until each
// holds an item, so intake stops only when all are full.
module box_pair_collision_resolve import bpcr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               item_valid,
	output logic               item_ready,
	input  logic               second_of_pair,
	input  logic signed [63:0] pos_x,
	input  logic signed [63:0] pos_y,
	input  logic signed [63:0] half_width,
	input  logic signed [63:0] half_height,
	input  logic [6:0]         phase,
	input  logic signed [63:0] scale_num,
	input  logic signed [63:0] scale_den,
	input  logic [6:0]         grid_cell,
	input  logic               tags_present,

	output logic               result_valid,
	input  logic               result_ready,
	output logic [1:0]         status,
	output logic [1:0]         outcome,
	output logic signed [63:0] separation_x,
	output logic signed [63:0] separation_y,
	output logic [62:0]        penetration_x,
	output logic [62:0]        penetration_y,
	output logic signed [63:0] correction_x,
	output logic signed [63:0] correction_y,
	output logic signed [63:0] corrected_x,
	output logic signed [63:0] corrected_y,
	output logic               phase_ok,
	output logic               scale_ok
);

	// Stage registers: the accepted item, then the two intermediate records.
	logic  valid_s1, second_s1, valid_s2, valid_s3, result_valid_q;
	obj_t  obj_s1;
	diff_t diff_s2;
	ovl_t  ovl_s3;
	res_t  res_q;

	diff_t diff_next;
	ovl_t  ovl_next;
	res_t  res_next;

	logic item_fire, res_free, rdy_s3, rdy_s2, adv_s3, adv_s2, leave_s1;

	// Backpressure runs from the result register toward the input. An A item
	// leaves stage one at once, because it only writes the held object.
	assign res_free   = !result_valid_q || result_ready;
	assign rdy_s3     = !valid_s3 || res_free;
	assign adv_s3     = valid_s3 && res_free;
	assign rdy_s2     = !valid_s2 || rdy_s3;
	assign adv_s2     = valid_s2 && rdy_s3;
	assign leave_s1   = valid_s1 && (!second_s1 || rdy_s2);
	assign item_ready = !valid_s1 || leave_s1;
	assign item_fire  = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_fire)
				valid_s1 <= 1'b1;
			else if (leave_s1)
				valid_s1 <= 1'b0;

			if (leave_s1 && second_s1)
				valid_s2 <= 1'b1;
			else if (adv_s2)
				valid_s2 <= 1'b0;

			if (adv_s2)
				valid_s3 <= 1'b1;
			else if (adv_s3)
				valid_s3 <= 1'b0;

			if (adv_s3)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	// Payload registers load on their stage's advance and need no reset.
	always_ff @(posedge clk) begin
		if (item_fire) begin
			second_s1 <= second_of_pair;
			obj_s1    <= '{pos_x: pos_x, pos_y: pos_y, half_width: half_width,
				half_height: half_height, phase: phase, scale_num: scale_num,
				scale_den: scale_den, grid_cell: grid_cell,
				tags_present: tags_present};
		end
		if (leave_s1 && second_s1)
			diff_s2 <= diff_next;
		if (adv_s2)
			ovl_s3 <= ovl_next;
		if (adv_s3)
			res_q <= res_next;
	end

	bpcr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.store  (leave_s1 && !second_s1),
		.obj    (obj_s1),
		.diff   (diff_next)
	);

	bpcr_overlap u_overlap (
		.diff (diff_s2),
		.ovl  (ovl_next)
	);

	bpcr_resolve u_resolve (
		.ovl (ovl_s3),
		.res (res_next)
	);

	assign result_valid  = result_valid_q;
	assign status        = res_q.status;
	assign outcome       = res_q.outcome;
	assign separation_x  = res_q.separation_x;
	assign separation_y  = res_q.separation_y;
	assign penetration_x = res_q.penetration_x;
	assign penetration_y = res_q.penetration_y;
	assign correction_x  = res_q.correction_x;
	assign correction_y  = res_q.correction_y;
	assign corrected_x   = res_q.corrected_x;
	assign corrected_y   = res_q.corrected_y;
	assign phase_ok      = res_q.phase_ok;
	assign scale_ok      = res_q.scale_ok;

endmodule
